/* rtl/cbf_pkg.sv */
// ============================================================================
// cbf_pkg: shared types and constants for the cubic Bezier flattener
// Coordinate width, stack geometry and the sequencer state type.
// ============================================================================
package cbf_pkg;

	localparam int MaxDepth = 6;
	localparam int CoordBits = 32;
	localparam int StackSlots = 8;
	localparam int SlotBits = $clog2(StackSlots);
	localparam int LevelBits = 3;
	// Stored coordinates carry room for subdivision growth.
	localparam int WideBits = 36;
	localparam int CurveBits = 8 * WideBits;

	localparam logic [0:0] CfgTolerance = 1'b0;
	localparam logic [0:0] CfgDepth = 1'b1;

	typedef logic signed [WideBits-1:0] wcoord_t;
	typedef wcoord_t [7:0] curve_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COL,
		ST_EVAL,
		ST_POP,
		ST_LOAD,
		ST_EMIT
	} state_t;

	function automatic wcoord_t half_floor(input logic signed [WideBits:0] v);
		half_floor = wcoord_t'(v >>> 1);
	endfunction

endpackage

/* rtl/cbf_if.sv */
// ============================================================================
// cbf_if: valid/ready channel interfaces
// Curve input, point output and configuration write channels.
// ============================================================================
interface cbf_curve_if;
	logic valid;
	logic ready;
	logic signed [31:0] start_x, start_y, ctrl_a_x, ctrl_a_y;
	logic signed [31:0] ctrl_b_x, ctrl_b_y, end_x, end_y;
	modport source (output valid, start_x, start_y, ctrl_a_x, ctrl_a_y,
		ctrl_b_x, ctrl_b_y, end_x, end_y, input ready);
	modport sink (input valid, start_x, start_y, ctrl_a_x, ctrl_a_y,
		ctrl_b_x, ctrl_b_y, end_x, end_y, output ready);
endinterface

interface cbf_point_if;
	logic valid;
	logic ready;
	logic signed [31:0] point_x, point_y;
	logic last_point;
	modport source (output valid, point_x, point_y, last_point, input ready);
	modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

interface cbf_cfg_if;
	logic valid;
	logic ready;
	logic [0:0] index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/cbf_ram.sv */
// ============================================================================
// cbf_ram: generic single-port RAM
// One address per cycle, written and read together; registered read data.
// ============================================================================
module cbf_ram #(
	parameter int Width = 8,
	parameter int Depth = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

/* rtl/cbf_colcheck.sv */
// ============================================================================
// cbf_colcheck: collinearity test of both control points
// Four 33x33 products, two at a time, compared after a shift by 16.
// ============================================================================
module cbf_colcheck
	import cbf_pkg::*;
(
	input  logic         clk,
	input  logic         start,
	input  curve_t       crv,
	output logic         collinear
);
	logic signed [32:0] dx, dy, ax, ay, bx, by;
	logic signed [65:0] p1_s1, p2_s1;
	logic phase_q;
	logic eq_a_q;

	assign dx = 33'(crv[6]) - 33'(crv[0]);
	assign dy = 33'(crv[7]) - 33'(crv[1]);
	assign ax = 33'(crv[2]) - 33'(crv[0]);
	assign ay = 33'(crv[3]) - 33'(crv[1]);
	assign bx = 33'(crv[4]) - 33'(crv[0]);
	assign by = 33'(crv[5]) - 33'(crv[1]);

	// With start high the first control point is multiplied, otherwise the other.
	always_ff @(posedge clk) begin
		phase_q <= start;
		p1_s1 <= start ? ax * dy : bx * dy;
		p2_s1 <= start ? ay * dx : by * dx;
		if (phase_q) begin
			eq_a_q <= (p1_s1 >>> 16) == (p2_s1 >>> 16);
		end
	end

	assign collinear = eq_a_q && ((p1_s1 >>> 16) == (p2_s1 >>> 16));
endmodule

/* rtl/cubic_bezier_flattener.sv */
// ============================================================================
// cubic_bezier_flattener: adaptive cubic Bezier subdivision to a polyline
// Depth-first de Casteljau splitting with a RAM-based stack of right halves.
// ============================================================================
// A collinear curve goes from ST_COL straight to ST_EMIT, which registers its end point.
// A subdivided curve passes through ST_EVAL once per split and per emitted
// point, and each pending half is read back from the stack RAM in ST_POP and ST_LOAD.
// One curve is taken at a time, giving at most 64 points.
// Reset clears the sequencer and restores tolerance 1.0 and depth limit 6;
// the stack RAM needs no clearing since every entry is written before use.
module cubic_bezier_flattener
	import cbf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	cbf_curve_if.sink curve_in,
	cbf_point_if.source point_out,
	cbf_cfg_if.sink cfg
);
	state_t state_q, state_d;
	logic [31:0] tol_q;
	logic [LevelBits-1:0] dlim_q;
	logic [LevelBits-1:0] lim;
	curve_t cur_q;
	logic [LevelBits-1:0] level_q;
	logic [SlotBits:0] top_q;
	logic [2:0] cnt_q;
	logic col;
	logic flat;
	logic split;
	curve_t left, right;
	logic ram_we;
	logic [SlotBits-1:0] ram_addr;
	logic [CurveBits+LevelBits-1:0] ram_wdata, ram_rdata;
	logic out_full_q;

	assign lim = (dlim_q > LevelBits'(MaxDepth)) ? LevelBits'(MaxDepth) : dlim_q;

	// Configuration writes are always taken; the source must send them only
	// between curves, while nothing is in flight; the block does not enforce it.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 32'd65536;
			dlim_q <= LevelBits'(MaxDepth);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CfgTolerance: tol_q <= cfg.data;
				CfgDepth: dlim_q <= cfg.data[LevelBits-1:0];
				default: ;
			endcase
		end
	end

	// The products start once the accepted curve sits in cur_q.
	cbf_colcheck u_col (
		.clk(clk), .start(state_q == ST_COL && cnt_q == 3'd0),
		.crv(cur_q), .collinear(col)
	);

	// Flatness: per-axis minimum of the two control deviations, summed and compared with the tolerance.
	always_comb begin
		logic signed [WideBits+2:0] nb [2];
		logic signed [WideBits+2:0] ne [2];
		logic [WideBits+2:0] m [2];
		logic [WideBits+3:0] sum;
		for (int a = 0; a < 2; a++) begin
			nb[a] = 3 * (WideBits+3)'(cur_q[2+a]) - 2 * (WideBits+3)'(cur_q[a])
				- (WideBits+3)'(cur_q[6+a]);
			ne[a] = 3 * (WideBits+3)'(cur_q[4+a]) - 2 * (WideBits+3)'(cur_q[6+a])
				- (WideBits+3)'(cur_q[a]);
			if (nb[a] < 0) nb[a] = -nb[a];
			if (ne[a] < 0) ne[a] = -ne[a];
			m[a] = (ne[a] < nb[a]) ? ne[a] : nb[a];
		end
		sum = (WideBits+4)'(m[0]) + (WideBits+4)'(m[1]);
		flat = sum <= (WideBits+4)'(tol_q);
	end

	// de Casteljau midpoint split for both axes.
	always_comb begin
		wcoord_t c0, c1, c2, q0, q1, p;
		for (int a = 0; a < 2; a++) begin
			c0 = half_floor((WideBits+1)'(cur_q[2+a]) + (WideBits+1)'(cur_q[4+a]));
			c1 = half_floor((WideBits+1)'(cur_q[a]) + (WideBits+1)'(cur_q[2+a]));
			c2 = half_floor((WideBits+1)'(cur_q[4+a]) + (WideBits+1)'(cur_q[6+a]));
			q0 = half_floor((WideBits+1)'(c0) + (WideBits+1)'(c1));
			q1 = half_floor((WideBits+1)'(c0) + (WideBits+1)'(c2));
			p = half_floor((WideBits+1)'(q0) + (WideBits+1)'(q1));
			left[a] = cur_q[a]; left[2+a] = c1; left[4+a] = q0; left[6+a] = p;
			right[a] = p; right[2+a] = q1; right[4+a] = c2; right[6+a] = cur_q[6+a];
		end
	end

	assign split = !(level_q >= lim || flat);

	// Stack RAM: one entry per pending right half with its level.
	assign ram_we = state_q == ST_EVAL && split && !top_q[SlotBits];
	assign ram_addr = (state_q == ST_EVAL && split) ? top_q[SlotBits-1:0]
		: SlotBits'(top_q - 1'b1);
	assign ram_wdata = {right, LevelBits'(level_q + 1'b1)};

	cbf_ram #(.Width(CurveBits + LevelBits), .Depth(StackSlots)) u_stack (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	assign curve_in.ready = state_q == ST_IDLE;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (curve_in.valid) state_d = ST_COL;
			ST_COL: if (cnt_q == 3'd2) state_d = col ? ST_EMIT : ST_EVAL;
			ST_EVAL: if (!split && !out_full_q) state_d = (top_q == '0) ? ST_IDLE : ST_POP;
				else if (!split) state_d = ST_EMIT;
			ST_EMIT: if (!out_full_q) state_d = (top_q == '0) ? ST_IDLE : ST_POP;
			ST_POP: state_d = ST_LOAD;
			ST_LOAD: state_d = ST_EVAL;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			top_q <= '0;
			level_q <= '0;
			cnt_q <= '0;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (point_out.valid && point_out.ready) out_full_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					top_q <= '0;
					level_q <= '0;
				end
				ST_COL: begin
					cnt_q <= cnt_q + 1'b1;
				end
				ST_EVAL: begin
					if (split) begin
						level_q <= level_q + 1'b1;
						if (!top_q[SlotBits]) top_q <= top_q + 1'b1;
					end else if (!out_full_q) begin
						out_full_q <= 1'b1;
					end
				end
				ST_EMIT: if (!out_full_q) out_full_q <= 1'b1;
				ST_POP: top_q <= top_q - 1'b1;
				ST_LOAD: level_q <= ram_rdata[LevelBits-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && curve_in.valid) begin
			cur_q[0] <= WideBits'(curve_in.start_x);
			cur_q[1] <= WideBits'(curve_in.start_y);
			cur_q[2] <= WideBits'(curve_in.ctrl_a_x);
			cur_q[3] <= WideBits'(curve_in.ctrl_a_y);
			cur_q[4] <= WideBits'(curve_in.ctrl_b_x);
			cur_q[5] <= WideBits'(curve_in.ctrl_b_y);
			cur_q[6] <= WideBits'(curve_in.end_x);
			cur_q[7] <= WideBits'(curve_in.end_y);
		end else if (state_q == ST_EVAL && split) begin
			cur_q <= left;
		end else if (state_q == ST_LOAD) begin
			cur_q <= ram_rdata[CurveBits+LevelBits-1:LevelBits];
		end
		if ((state_q == ST_EVAL && !split && !out_full_q) ||
			(state_q == ST_EMIT && !out_full_q)) begin
			point_out.point_x <= cur_q[6][31:0];
			point_out.point_y <= cur_q[7][31:0];
			point_out.last_point <= top_q == '0;
		end
	end

	assign point_out.valid = out_full_q;

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		curve_in.ready |-> state_q == ST_IDLE)
		else $error("input accepted while busy");
	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= (SlotBits+1)'(StackSlots))
		else $error("stack overflow");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		point_out.valid && !point_out.ready |=> point_out.valid)
		else $error("point dropped");
`endif
endmodule
